>>> rtl/core/antirt_pkg.sv
// Package with types and constants for the aging neighbor table block.
package antirt_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 16;
    localparam int POS_W    = 20;
    localparam int AGE_W    = 32;
    localparam int RANGE_W  = 20;
    localparam int BINW_W   = 16;
    localparam int BEAC_W   = 16;
    localparam int SUM_W    = 48;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_BEACON = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SWEEP    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUERY    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_AGE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINW  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SQRT, S_DIVB, S_BINRD, S_BINWR,
        S_SWEEP, S_QDIV, S_QSUM, S_MDIV, S_DONE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TIME_W-1:0] now_ticks;
        logic [ID_W-1:0]   sender_id;
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [POS_W-1:0] sender_x;
        logic signed [POS_W-1:0] sender_y;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [6:0]          neighbor_count;
        logic [TIME_W-1:0]   interval_ticks;
        logic                interval_in_range;
        logic [6:0]          evicted_count;
        logic [TIME_W-1:0]   mean_interval;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg_item;

endpackage

>>> rtl/core/antirt_if.sv
// Valid/ready channel interfaces for input, output and configuration items.
interface antirt_in_if;
    import antirt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface antirt_out_if;
    import antirt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface antirt_cfg_if;
    import antirt_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/antirt_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module antirt_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_shift;

    assign n_shift = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (n_shift >= {1'b0, r_den}) begin
                r_rem  <= n_shift - {1'b0, r_den};
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_shift;
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> rtl/core/aging_neighbor_table_irt_histogram_top.sv
// Top level of the aging neighbor table with inter-reception-time histogram.
//
// Channels: in_ch takes one item per request (beacon, aging tick or mean query),
// out_ch returns exactly one result item per input item. The user must write
// the age limit, report range and bin width over cfg_ch only while the block
// is idle; the block itself does not enforce this. One item is handled at a
// time. A beacon scans the table memory, one entry a cycle, then for an update
// runs a 21-step square root, a 64-step bin division and a read-modify-write
// of the histogram memory. A tick scans each entry, evicting valid ones whose
// age has reached the age limit and rewriting the rest with a zero beacon
// count. A query divides the range by the bin width, sums the bins one a
// cycle and divides the sum by the count.
// After reset the histogram memory is cleared, one bin a cycle, during which
// no item is accepted; the table needs no clearing because its valid bits are
// flip-flops. The result waits in the output register while the receiver
// stalls, and the next input item is not taken until that result has left.
module aging_neighbor_table_irt_histogram_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int BIN_COUNT     = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    antirt_in_if.sink    in_ch,
    antirt_out_if.source out_ch,
    antirt_cfg_if.sink   cfg_ch
);
    import antirt_pkg::*;

    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int BW = $clog2(BIN_COUNT + 1);
    localparam int BINS = BIN_COUNT + 1;
    localparam int NCW = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W = ID_W + TIME_W + BEAC_W;
    localparam int IW = ((TW > BW) ? TW : BW) + 1;

    logic [AGE_W-1:0]   r_age;
    logic [RANGE_W-1:0] r_range;
    logic [BINW_W-1:0]  r_binw;

    t_state r_state, n_state;
    t_in_item r_in;
    t_out_item r_out;
    logic r_out_valid;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [SLOT_W-1:0] slot_mem [TABLE_ENTRIES];
    logic [SUM_W+CNT_W-1:0] bin_mem [BINS];

    logic [IW-1:0] r_idx;
    logic [TW-1:0] r_rd_q;
    logic r_rd_v;
    logic [SLOT_W-1:0] r_slot_rd;
    logic r_hit_f, r_free_f;
    logic [TW-1:0] r_free;
    logic [NCW-1:0] r_count, r_evict;
    logic [BW:0] r_clr;
    logic [BW-1:0] r_bin;
    logic [SUM_W+CNT_W-1:0] r_bin_rd;
    logic [41:0] r_sqv, r_sqres;
    logic [5:0] r_sqn;
    logic [TIME_W-1:0] r_ival;
    logic r_inrange, r_collect;
    logic [SUM_W+8:0] r_qsum;
    logic [CNT_W+8:0] r_qcnt;
    logic [BW:0] r_qk;

    logic [BINW_W-1:0] w_eff;
    assign w_eff = (r_binw == '0) ? BINW_W'(1) : r_binw;

    logic div_start, div_done;
    logic [63:0] div_num, div_quot;
    logic [40:0] div_den;
    logic r_div_go;
    logic [63:0] r_div_num;
    logic [40:0] r_div_den;
    assign div_start = r_div_go;
    assign div_num = r_div_num;
    assign div_den = r_div_den;

    antirt_divider #(.NUM_W(64), .DEN_W(41)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    logic clr_busy;
    assign clr_busy = (r_clr != (BW+1)'(BINS));
    assign in_ch.ready = (r_state == S_IDLE) && !r_out_valid && !clr_busy;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data = r_out;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= AGE_W'(1000);
            r_range <= RANGE_W'(1000);
            r_binw <= BINW_W'(100);
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data.index)
                CFG_AGE:   r_age <= cfg_ch.data.data;
                CFG_RANGE: r_range <= cfg_ch.data.data[RANGE_W-1:0];
                CFG_BINW:  r_binw <= cfg_ch.data.data[BINW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // The scan index runs ahead of the entry being handled, held in r_slot_rd and r_rd_q.
    logic scan_end;
    assign scan_end = (r_idx == IW'(TABLE_ENTRIES)) && !r_rd_v;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc) n_state = (in_ch.data.func == FUNC_BEACON) ? S_SCAN :
                (in_ch.data.func == FUNC_TICK) ? S_SWEEP : S_QDIV;
            S_SCAN: if (scan_end) n_state = (r_hit_f) ? S_SQRT : S_DONE;
            S_SQRT: if (r_sqn == 6'd0) n_state = S_DIVB;
            S_DIVB: if (div_done) n_state = S_BINRD;
            S_BINRD: n_state = S_BINWR;
            S_BINWR: n_state = S_DONE;
            S_SWEEP: if (scan_end) n_state = S_DONE;
            S_QDIV: if (div_done) n_state = S_QSUM;
            S_QSUM: if (r_idx == IW'(0) && r_qk == '0 && !r_rd_v) n_state = S_MDIV;
            S_MDIV: if (div_done || r_qcnt == '0) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [SLOT_W-1:0] cur_slot;
    logic [ID_W-1:0] cur_id;
    logic [TIME_W-1:0] cur_seen;
    logic [BEAC_W-1:0] cur_beac;
    assign cur_slot = r_slot_rd;
    assign cur_id = cur_slot[SLOT_W-1 -: ID_W];
    assign cur_seen = cur_slot[BEAC_W +: TIME_W];
    assign cur_beac = cur_slot[BEAC_W-1:0];

    logic signed [POS_W:0] dx, dy;
    assign dx = $signed({r_in.sender_x[POS_W-1], r_in.sender_x})
        - $signed({r_in.own_x[POS_W-1], r_in.own_x});
    assign dy = $signed({r_in.sender_y[POS_W-1], r_in.sender_y})
        - $signed({r_in.own_y[POS_W-1], r_in.own_y});

    logic signed [41:0] dx_sq, dy_sq;
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    logic [20:0] sq_try;
    logic [41:0] sq_try_sq;
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] b_cnt;
    logic [SUM_W:0] b_sum_n;
    assign sq_try = r_sqres[20:0] | (21'd1 << (r_sqn - 6'd1));
    assign sq_try_sq = sq_try * sq_try;
    assign b_sum = r_bin_rd[SUM_W+CNT_W-1 -: SUM_W];
    assign b_cnt = r_bin_rd[CNT_W-1:0];
    assign b_sum_n = {1'b0, b_sum} + (SUM_W+1)'(r_ival);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_out_valid <= 1'b0;
            r_clr <= '0;
            r_div_go <= 1'b0;
            r_rd_v <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (clr_busy) begin
                bin_mem[r_clr[BW-1:0]] <= '0;
                r_clr <= r_clr + 1'b1;
            end
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            r_rd_v <= 1'b0;
            case (r_state)
                S_IDLE: if (acc) begin
                    r_in <= in_ch.data;
                    r_idx <= '0;
                    r_hit_f <= 1'b0;
                    r_free_f <= 1'b0;
                    r_evict <= '0;
                    r_qsum <= '0;
                    r_qcnt <= '0;
                    r_count <= NCW'($countones(r_valid));
                    if (in_ch.data.func != FUNC_BEACON && in_ch.data.func != FUNC_TICK)
                    begin
                        r_div_go <= 1'b1;
                        r_div_num <= 64'(r_range);
                        r_div_den <= 41'(w_eff);
                    end
                end
                S_SCAN, S_SWEEP: begin
                    if (r_idx != IW'(TABLE_ENTRIES)) begin
                        r_slot_rd <= slot_mem[r_idx[TW-1:0]];
                        r_rd_q <= r_idx[TW-1:0];
                        r_rd_v <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_v && r_state == S_SCAN) begin
                        if (r_valid[r_rd_q]) begin
                            if (!r_hit_f && cur_id == r_in.sender_id) begin
                                r_hit_f <= 1'b1;
                            end
                        end else if (!r_free_f) begin
                            r_free_f <= 1'b1;
                            r_free <= r_rd_q;
                        end
                    end
                    if (r_rd_v && r_state == S_SWEEP && r_valid[r_rd_q]) begin
                        if ((r_in.now_ticks - cur_seen) >= r_age) begin
                            r_valid[r_rd_q] <= 1'b0;
                            r_evict <= r_evict + 1'b1;
                        end else begin
                            slot_mem[r_rd_q] <= {cur_id, cur_seen, BEAC_W'(0)};
                        end
                    end
                    if (r_rd_v && r_state == S_SCAN && r_valid[r_rd_q] && !r_hit_f
                        && cur_id == r_in.sender_id) begin
                        r_ival <= r_in.now_ticks - cur_seen;
                        slot_mem[r_rd_q] <= {cur_id, r_in.now_ticks,
                            (cur_beac == '1) ? cur_beac : cur_beac + 1'b1};
                    end
                    if (scan_end && r_state == S_SCAN) begin
                        if (r_hit_f) begin
                            r_sqv <= $unsigned(dx_sq) + $unsigned(dy_sq);
                            r_sqres <= '0;
                            r_sqn <= 6'd21;
                        end else if (r_free_f) begin
                            r_valid[r_free] <= 1'b1;
                            slot_mem[r_free] <= {r_in.sender_id, r_in.now_ticks,
                                BEAC_W'(1)};
                        end
                    end
                end
                S_SQRT: begin
                    if (r_sqn != 6'd0) begin
                        if (sq_try_sq <= r_sqv) r_sqres <= {21'd0, sq_try};
                        r_sqn <= r_sqn - 1'b1;
                    end else begin
                        r_inrange <= (r_sqres <= 42'(r_range));
                        r_collect <= (r_sqres <= 42'(w_eff) * 42'(BIN_COUNT));
                        r_div_go <= 1'b1;
                        r_div_num <= 64'(r_sqres);
                        r_div_den <= 41'(w_eff);
                    end
                end
                S_DIVB: if (div_done) begin
                    r_bin <= (div_quot > 64'(BIN_COUNT)) ? BW'(BIN_COUNT)
                        : div_quot[BW-1:0];
                end
                S_BINRD: r_bin_rd <= bin_mem[r_bin];
                S_BINWR: if (r_collect) begin
                    bin_mem[r_bin] <= {b_sum_n[SUM_W] ? {SUM_W{1'b1}} : b_sum_n[SUM_W-1:0],
                        (b_cnt == '1) ? b_cnt : b_cnt + 1'b1};
                end
                S_QDIV: if (div_done) begin
                    r_qk <= (div_quot > 64'(BINS)) ? (BW+1)'(BINS) : div_quot[BW:0];
                    r_idx <= '0;
                end
                S_QSUM: begin
                    if (r_qk != '0) begin
                        r_bin_rd <= bin_mem[r_idx[BW-1:0]];
                        r_idx <= r_idx + 1'b1;
                        r_qk <= r_qk - 1'b1;
                        r_rd_v <= 1'b1;
                    end else if (!r_rd_v) begin
                        r_idx <= '0;
                        r_div_go <= (r_qcnt != '0);
                        r_div_num <= 64'(r_qsum);
                        r_div_den <= 41'(r_qcnt);
                    end
                    if (r_rd_v) begin
                        r_qsum <= r_qsum + (SUM_W+9)'(b_sum);
                        r_qcnt <= r_qcnt + (CNT_W+9)'(b_cnt);
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out.neighbor_count <= 7'(r_count);
                    r_out.interval_ticks <= '0;
                    r_out.interval_in_range <= 1'b0;
                    r_out.evicted_count <= '0;
                    r_out.mean_interval <= '0;
                    case (r_in.func)
                        FUNC_BEACON: begin
                            if (r_hit_f) begin
                                r_out.status <= ST_UPDATED;
                                r_out.interval_ticks <= r_ival;
                                r_out.interval_in_range <= r_inrange;
                            end else if (r_free_f) r_out.status <= ST_INSERTED;
                            else r_out.status <= ST_DROPPED;
                        end
                        FUNC_TICK: begin
                            r_out.status <= ST_SWEEP;
                            r_out.evicted_count <= 7'(r_evict);
                        end
                        default: begin
                            r_out.status <= ST_QUERY;
                            if (r_qcnt != '0) r_out.mean_interval <=
                                (div_quot > 64'hFFFF_FFFF) ? '1 : div_quot[TIME_W-1:0];
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid) else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !in_ch.ready) else $error("accept while result pending");
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (r_state == S_IDLE)) else $error("item during clear");
endmodule
